// ----- src/ldm_pkg.sv -----
`timescale 1ns / 1ps
package ldm_pkg;

	localparam int COORD_W = 12;
	localparam int SCALE_W = 13;
	localparam int DIMS_W  = 3;
	localparam int NCOORD  = 4;
	// Index arithmetic is sized for the largest supported store (2^20 cells).
	localparam int IDX_W   = 21;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_DIMS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE3 = 3'd4;

	typedef enum logic [1:0] {
		REQ_CLEAR = 2'd0,
		REQ_MARK  = 2'd1,
		REQ_QUERY = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_STORE = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [COORD_W-1:0] coord_0;
		logic [COORD_W-1:0] coord_1;
		logic [COORD_W-1:0] coord_2;
		logic [COORD_W-1:0] coord_3;
	} in_t;

	typedef struct packed {
		logic       dominated;
		logic [1:0] status;
	} out_t;

	typedef struct packed {
		req_t                           op;
		status_t                        status;
		logic                           empty;
		logic [IDX_W-1:0]               idx;
		logic [IDX_W-1:0]               base;
		logic [NCOORD-1:0][SCALE_W-1:0] lo;
		logic [NCOORD-1:0][SCALE_W-1:0] hi;
		logic [NCOORD-1:0][IDX_W-1:0]   w;
	} cmd_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CALC,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_SWEEP,
		B_IDLE,
		B_READ,
		B_CHECK,
		B_RUN
	} back_state_t;

endpackage

// ----- src/ldm_fifo.sv -----
`timescale 1ns / 1ps
module ldm_fifo
	import ldm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t din,
	input  logic pop,
	output cmd_t dout,
	output logic full,
	output logic empty
);

	cmd_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_q <= ~wr_q;
			end
			if (pop && !empty) begin
				rd_q <= ~rd_q;
			end
			unique case ({push && !full, pop && !empty})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- src/ldm_front.sv -----
`timescale 1ns / 1ps
module ldm_front
	import ldm_pkg::*;
#(
	parameter int LATTICE_CELLS = 4096,
	parameter int MAX_DIMS      = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  in_t                  request,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SCALE_W-1:0]   cfg_data,
	input  logic                 q_full,
	output logic                 push,
	output cmd_t                 cmd,
	output logic                 f_busy
);

	localparam int TOP_DIMS = (MAX_DIMS < NCOORD) ? MAX_DIMS : NCOORD;
	localparam int PM_W = IDX_W + SCALE_W;
	localparam int TM_W = IDX_W + COORD_W;
	localparam logic [PM_W-1:0]  CELLS_PM = PM_W'(LATTICE_CELLS);
	localparam logic [IDX_W-1:0] CELLS_IX = IDX_W'(LATTICE_CELLS);
	localparam logic [IDX_W-1:0] SAT_IX   = IDX_W'(LATTICE_CELLS + 1);

	front_state_t state_q, state_d;

	logic [DIMS_W-1:0]  dims_q;
	logic [SCALE_W-1:0] scale_q [NCOORD];
	logic [DIMS_W-1:0]  nd;

	req_t                  req_q;
	logic [COORD_W-1:0]    c_q   [NCOORD];
	logic [SCALE_W-1:0]    s_q   [NCOORD];
	logic [NCOORD-1:0]     used_q;
	logic [1:0]            k_q;
	logic [IDX_W-1:0]      prod_q;
	logic [IDX_W-1:0]      idx_q;
	logic [IDX_W-1:0]      wsum_q;
	logic                  bad_q;
	logic                  empty_q;
	logic [IDX_W-1:0]      w_q   [NCOORD];

	logic [PM_W-1:0]    pm;
	logic [TM_W-1:0]    tm;
	logic [IDX_W-1:0]   prod_sat;
	logic [COORD_W-1:0] in_c [NCOORD];

	always_comb begin
		if (dims_q < DIMS_W'(2)) begin
			nd = DIMS_W'(2);
		end else if (dims_q > DIMS_W'(TOP_DIMS)) begin
			nd = DIMS_W'(TOP_DIMS);
		end else begin
			nd = dims_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q     <= DIMS_W'(2);
			scale_q[0] <= SCALE_W'(64);
			scale_q[1] <= SCALE_W'(64);
			scale_q[2] <= SCALE_W'(1);
			scale_q[3] <= SCALE_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DIMS:   dims_q     <= cfg_data[DIMS_W-1:0];
				CFG_SCALE0: scale_q[0] <= cfg_data;
				CFG_SCALE1: scale_q[1] <= cfg_data;
				CFG_SCALE2: scale_q[2] <= cfg_data;
				CFG_SCALE3: scale_q[3] <= cfg_data;
				default:    dims_q     <= dims_q;
			endcase
		end
	end

	assign in_c[0] = request.coord_0;
	assign in_c[1] = request.coord_1;
	assign in_c[2] = request.coord_2;
	assign in_c[3] = request.coord_3;

	always_comb begin
		pm = PM_W'(prod_q) * PM_W'(s_q[k_q]);
		tm = TM_W'(c_q[k_q]) * TM_W'(prod_q);
		prod_sat = (pm > CELLS_PM) ? SAT_IX : pm[IDX_W-1:0];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (take) begin
					if (request.req_type == REQ_MARK || request.req_type == REQ_QUERY) begin
						state_d = F_CALC;
					end else begin
						state_d = F_PUSH;
					end
				end
			end
			F_CALC: begin
				if (k_q == 2'd3) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				if (!q_full) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		push   = (state_q == F_PUSH) && !q_full;
		f_busy = (state_q != F_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && take) begin
			req_q   <= req_t'(request.req_type);
			k_q     <= 2'd0;
			prod_q  <= IDX_W'(1);
			idx_q   <= '0;
			wsum_q  <= '0;
			bad_q   <= 1'b0;
			empty_q <= 1'b0;
			for (int k = 0; k < NCOORD; k++) begin
				used_q[k] <= (DIMS_W'(k) < nd);
				c_q[k]    <= (DIMS_W'(k) < nd) ? in_c[k] : '0;
				s_q[k]    <= (DIMS_W'(k) < nd) ? scale_q[k] : SCALE_W'(1);
			end
		end else if (state_q == F_CALC) begin
			w_q[k_q] <= prod_q;
			prod_q   <= prod_sat;
			idx_q    <= idx_q + tm[IDX_W-1:0];
			if (used_q[k_q] && k_q != 2'd0) begin
				wsum_q <= wsum_q + prod_q;
			end
			if (SCALE_W'(c_q[k_q]) >= s_q[k_q]) begin
				bad_q <= 1'b1;
			end
			if (used_q[k_q] && (SCALE_W'(c_q[k_q]) + SCALE_W'(1) >= s_q[k_q])) begin
				empty_q <= 1'b1;
			end
			k_q <= k_q + 2'd1;
		end
	end

	always_comb begin
		cmd.op    = req_q;
		cmd.empty = empty_q;
		cmd.idx   = idx_q;
		cmd.base  = idx_q - IDX_W'(c_q[0]) + wsum_q;
		for (int k = 0; k < NCOORD; k++) begin
			cmd.lo[k] = used_q[k] ? SCALE_W'(c_q[k]) + SCALE_W'(1) : '0;
			cmd.hi[k] = s_q[k] - SCALE_W'(1);
			cmd.w[k]  = w_q[k];
		end
		if (req_q != REQ_MARK && req_q != REQ_QUERY) begin
			cmd.status = STAT_OK;
		end else if (prod_q > CELLS_IX) begin
			cmd.status = STAT_STORE;
		end else if (bad_q) begin
			cmd.status = STAT_RANGE;
		end else begin
			cmd.status = STAT_OK;
		end
	end

endmodule

// ----- src/ldm_back.sv -----
`timescale 1ns / 1ps
module ldm_back
	import ldm_pkg::*;
#(
	parameter int LATTICE_CELLS = 4096
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  cmd_t cmd,
	output logic pop,
	output logic init_busy,
	output logic done,
	output out_t result
);

	// One memory row holds a run of consecutive cells.
	localparam int ROW_W = (LATTICE_CELLS >= 64) ? 64 : 16;
	localparam int LW    = $clog2(ROW_W);
	localparam int ROWS  = (LATTICE_CELLS + ROW_W - 1) / ROW_W;
	localparam int RAW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam logic [RAW-1:0] LAST_ROW = RAW'(ROWS - 1);

	back_state_t state_q, state_d;

	logic [ROW_W-1:0] mem [ROWS];
	logic [ROW_W-1:0] rdata_q;

	cmd_t             cmd_q;
	logic [RAW-1:0]   row_q;
	logic             emit_q;
	logic             init_q;
	logic [IDX_W-1:0] pos_q, end_q;
	logic [IDX_W-1:0] b1_q, b2_q, b3_q;
	logic [SCALE_W-1:0] cur1_q, cur2_q, cur3_q;
	logic             done_q;
	out_t             res_q;

	logic             we;
	logic [RAW-1:0]   waddr;
	logic [RAW-1:0]   raddr;
	logic [ROW_W-1:0] wmask;
	logic [ROW_W-1:0] wdata;

	logic [IDX_W-1:0]   row_end, seg_end;
	logic [LW-1:0]      lo_b, hi_b;
	logic               run_last;
	logic               walk_done;
	logic [IDX_W-1:0]   nb1, nb2, nb3;
	logic [SCALE_W-1:0] ncur1, ncur2, ncur3;
	logic               own_bit;
	logic               start_ok;

	assign raddr   = RAW'(cmd_q.idx >> LW);
	assign own_bit = rdata_q[cmd_q.idx[LW-1:0]];
	assign start_ok = (cmd.op == REQ_MARK || cmd.op == REQ_QUERY) && cmd.status == STAT_OK;

	always_comb begin
		row_end  = pos_q | IDX_W'(ROW_W - 1);
		seg_end  = (end_q < row_end) ? end_q : row_end;
		run_last = (seg_end == end_q);
		lo_b     = pos_q[LW-1:0];
		hi_b     = seg_end[LW-1:0];
	end

	// Odometer over dimensions one to three; each step gives a new run along dimension zero.
	always_comb begin
		ncur1     = cur1_q;
		ncur2     = cur2_q;
		ncur3     = cur3_q;
		nb1       = b1_q;
		nb2       = b2_q;
		nb3       = b3_q;
		walk_done = 1'b0;
		if (cur1_q < cmd_q.hi[1]) begin
			ncur1 = cur1_q + SCALE_W'(1);
			nb1   = b1_q + cmd_q.w[1];
		end else if (cur2_q < cmd_q.hi[2]) begin
			ncur1 = cmd_q.lo[1];
			ncur2 = cur2_q + SCALE_W'(1);
			nb2   = b2_q + cmd_q.w[2];
			nb1   = nb2;
		end else if (cur3_q < cmd_q.hi[3]) begin
			ncur1 = cmd_q.lo[1];
			ncur2 = cmd_q.lo[2];
			ncur3 = cur3_q + SCALE_W'(1);
			nb3   = b3_q + cmd_q.w[3];
			nb2   = nb3;
			nb1   = nb3;
		end else begin
			walk_done = 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_SWEEP: begin
				if (row_q == LAST_ROW) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				if (!q_empty) begin
					if (cmd.op == REQ_CLEAR) begin
						state_d = B_SWEEP;
					end else if (start_ok) begin
						state_d = B_READ;
					end
				end
			end
			B_READ:  state_d = B_CHECK;
			B_CHECK: begin
				if (cmd_q.op == REQ_QUERY || own_bit || cmd_q.empty) begin
					state_d = B_IDLE;
				end else begin
					state_d = B_RUN;
				end
			end
			B_RUN: begin
				if (run_last && walk_done) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop   = (state_q == B_IDLE) && !q_empty;
		we    = 1'b0;
		waddr = row_q;
		wmask = '1;
		wdata = '0;
		unique case (state_q)
			B_SWEEP: begin
				we = 1'b1;
			end
			B_RUN: begin
				we    = 1'b1;
				waddr = RAW'(pos_q >> LW);
				wmask = ({ROW_W{1'b1}} << lo_b) & ({ROW_W{1'b1}} >> (LW'(ROW_W - 1) - hi_b));
				wdata = '1;
			end
			default: we = 1'b0;
		endcase
	end

	assign init_busy = init_q;
	assign done      = done_q;
	assign result    = res_q;

	always_ff @(posedge clk) begin
		if (we) begin
			for (int b = 0; b < ROW_W; b++) begin
				if (wmask[b]) begin
					mem[waddr][b] <= wdata[b];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_SWEEP;
			row_q   <= '0;
			emit_q  <= 1'b0;
			init_q  <= 1'b1;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			unique case (state_q)
				B_SWEEP: begin
					row_q <= row_q + RAW'(1);
					if (row_q == LAST_ROW) begin
						init_q <= 1'b0;
						done_q <= emit_q;
					end
				end
				B_IDLE: begin
					if (!q_empty) begin
						row_q  <= '0;
						emit_q <= 1'b1;
						done_q <= (cmd.op != REQ_CLEAR) && !start_ok;
					end
				end
				B_CHECK: done_q <= 1'b1;
				default: done_q <= 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_SWEEP: begin
				res_q.dominated <= 1'b0;
				res_q.status    <= STAT_OK;
			end
			B_IDLE: begin
				cmd_q           <= cmd;
				res_q.dominated <= 1'b0;
				res_q.status    <= (cmd.op == REQ_MARK || cmd.op == REQ_QUERY) ? cmd.status
					: STAT_OK;
			end
			B_CHECK: begin
				res_q.dominated <= own_bit;
				res_q.status    <= STAT_OK;
				cur1_q <= cmd_q.lo[1];
				cur2_q <= cmd_q.lo[2];
				cur3_q <= cmd_q.lo[3];
				b1_q   <= cmd_q.base;
				b2_q   <= cmd_q.base;
				b3_q   <= cmd_q.base;
				pos_q  <= cmd_q.base + IDX_W'(cmd_q.lo[0]);
				end_q  <= cmd_q.base + IDX_W'(cmd_q.hi[0]);
			end
			B_RUN: begin
				if (run_last) begin
					cur1_q <= ncur1;
					cur2_q <= ncur2;
					cur3_q <= ncur3;
					b1_q   <= nb1;
					b2_q   <= nb2;
					b3_q   <= nb3;
					pos_q  <= nb1 + IDX_W'(cmd_q.lo[0]);
					end_q  <= nb1 + IDX_W'(cmd_q.hi[0]);
				end else begin
					pos_q <= seg_end + IDX_W'(1);
				end
			end
			default: pos_q <= pos_q;
		endcase
	end

endmodule

// ----- src/lattice_dominance_marker.sv -----
`timescale 1ns / 1ps
// A query or mark reports once the front has computed its index and the back has read and checked its cell;
// one with an error status reports from the back's idle state; a clear reports once the map is swept.
// The front holds busy while it handles a request, so it takes a new one only after pushing the last;
// the back reads and checks each query or mark, and a mark then writes its cells one row segment at a time.
// After reset the map is swept clear with busy held high.
// Results appear with done for one cycle; the receiver cannot stall them.
module lattice_dominance_marker
	import ldm_pkg::*;
#(
	parameter int LATTICE_CELLS = 4096,
	parameter int MAX_DIMS      = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  in_t                  request,
	output logic                 done,
	output out_t                 result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SCALE_W-1:0]   cfg_data
);

	logic f_busy, init_busy, take;
	logic push, pop, q_full, q_empty;
	cmd_t f_cmd, q_cmd;

	assign busy = f_busy || init_busy;
	assign take = start && !busy;

	ldm_front #(
		.LATTICE_CELLS(LATTICE_CELLS),
		.MAX_DIMS(MAX_DIMS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.request(request),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.q_full(q_full),
		.push(push),
		.cmd(f_cmd),
		.f_busy(f_busy)
	);

	ldm_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.din(f_cmd),
		.pop(pop),
		.dout(q_cmd),
		.full(q_full),
		.empty(q_empty)
	);

	ldm_back #(
		.LATTICE_CELLS(LATTICE_CELLS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.cmd(q_cmd),
		.pop(pop),
		.init_busy(init_busy),
		.done(done),
		.result(result)
	);

endmodule
